// File: hdl/dpds_pkg.sv
// ----------------------------------------------------------------------------
// dpds_pkg
// Shared widths, reset values, register indexes and control types for the
// dual-side proportional drive with slew limit and settle detection.
// ----------------------------------------------------------------------------
package dpds_pkg;

    localparam int POS_WIDTH  = 24;
    localparam int FRAC_BITS  = 8;

    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int SPEED_W    = 16;
    localparam int BAND_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = POS_WIDTH;

    localparam int ERR_W      = POS_WIDTH + 1;
    localparam int CMD_W      = ERR_W + GAIN_W + 1;
    localparam int SUM_W      = SPEED_W + 2;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(1 << FRAC_BITS);
    localparam logic [LIM_W-1:0]   MAX_RST   = LIM_W'(100 << FRAC_BITS);
    localparam logic [LIM_W-1:0]   STEP_RST  = LIM_W'(((4 << FRAC_BITS) + 2) / 5);
    localparam logic [BAND_W-1:0]  BAND_RST  = BAND_W'(10);
    localparam logic [BAND_W-1:0]  LIMIT_RST = BAND_W'(100);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 3'd0,
        REG_GAIN   = 3'd1,
        REG_MAX    = 3'd2,
        REG_STEP   = 3'd3,
        REG_BAND   = 3'd4,
        REG_LIMIT  = 3'd5,
        REG_TURN   = 3'd6
    } dpds_reg_t;

    // per-word control from the settle unit to both lanes
    typedef struct packed {
        logic restart;  // word carries restart: start from zero velocity
        logic load;     // word updates the lane state
        logic clear;    // word completes the move: velocity goes to zero
    } dpds_lane_ctrl_t;

endpackage

// File: hdl/dual_p_drive_slew_settle.sv
// ----------------------------------------------------------------------------
// dual_p_drive_slew_settle
// Two-sided proportional position drive with slew limit and settle detect.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per control tick with both encoder positions and a
//   restart flag. m_ channel: one word per input word with both drive
//   velocities and the finished flag.
//   cfg channel: register writes (index, data); always ready. The user is to
//   write only while the block is idle; the block itself does not enforce
//   this. Indexes beyond the register list are dropped. An accepted word's
//   velocities are registered and shown on m_ in the next cycle. Throughput:
//   one word per cycle while m_ takes each result; lanes and settle merge
//   are combinational; the velocity registers are the output register.
//   Stall: s_ready stays high while the output is empty or being taken, so
//   a new word enters in the same cycle the previous result leaves. When m_
//   stalls, the result holds and s_ready drops.
//   Reset: velocities, settle count, done and the output valid clear;
//   registers return to their defaults (gain 1.0, limit 100%, step 0.8%,
//   band 10, settle limit 100, forward mode).
// ----------------------------------------------------------------------------
module dual_p_drive_slew_settle
    import dpds_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [POS_WIDTH-1:0]  s_left_position,
    input  logic signed [POS_WIDTH-1:0]  s_right_position,
    input  logic                         s_restart,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [SPEED_W-1:0]    m_left_drive,
    output logic signed [SPEED_W-1:0]    m_right_drive,
    output logic                         m_finished
);

    logic signed [POS_WIDTH-1:0] target_reg;
    logic [GAIN_W-1:0]           gain_reg;
    logic [LIM_W-1:0]            max_reg;
    logic [LIM_W-1:0]            step_reg;
    logic [BAND_W-1:0]           band_reg;
    logic [BAND_W-1:0]           limit_reg;
    logic                        turn_reg;

    logic                        m_valid_reg, m_valid_next;
    logic                        accept;
    logic                        left_in_band, right_in_band;
    dpds_lane_ctrl_t             ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
            gain_reg   <= GAIN_RST;
            max_reg    <= MAX_RST;
            step_reg   <= STEP_RST;
            band_reg   <= BAND_RST;
            limit_reg  <= LIMIT_RST;
            turn_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (dpds_reg_t'(cfg_index))
                REG_TARGET: target_reg <= cfg_data;
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_MAX:    max_reg    <= cfg_data[LIM_W-1:0];
                REG_STEP:   step_reg   <= cfg_data[LIM_W-1:0];
                REG_BAND:   band_reg   <= cfg_data[BAND_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[BAND_W-1:0];
                REG_TURN:   turn_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    dpds_lane u_left (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .target      (target_reg),
        .position    (s_left_position),
        .negate      (1'b0),
        .gain        (gain_reg),
        .max_cmd     (max_reg),
        .slew_step   (step_reg),
        .settle_band (band_reg),
        .ctrl        (ctrl),
        .in_band     (left_in_band),
        .speed       (m_left_drive)
    );

    dpds_lane u_right (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .target      (target_reg),
        .position    (s_right_position),
        .negate      (turn_reg),
        .gain        (gain_reg),
        .max_cmd     (max_reg),
        .slew_step   (step_reg),
        .settle_band (band_reg),
        .ctrl        (ctrl),
        .in_band     (right_in_band),
        .speed       (m_right_drive)
    );

    dpds_settle u_settle (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .restart       (s_restart),
        .left_in_band  (left_in_band),
        .right_in_band (right_in_band),
        .settle_limit  (limit_reg),
        .ctrl          (ctrl),
        .done          (m_finished)
    );

    assign m_valid = m_valid_reg;

    // a finished move always drives both sides at zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_finished |-> (m_left_drive == '0) && (m_right_drive == '0))
        else $error("finished with nonzero drive");

    // an accepted word always produces a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted word produced no result");

    // an empty output never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // the drive state only moves when a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(accept) && $past(aresetn) |-> $stable(m_left_drive) && $stable(m_finished))
        else $error("state changed without an accepted word");

endmodule

// File: hdl/dpds_lane.sv
// ----------------------------------------------------------------------------
// dpds_lane
// One drive side: error, proportional command, clamp or slew, velocity
// register, and the in-band flag for the settle unit.
// ----------------------------------------------------------------------------
module dpds_lane
    import dpds_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic signed [POS_WIDTH-1:0] target,
    input  logic signed [POS_WIDTH-1:0] position,
    input  logic                        negate,
    input  logic        [GAIN_W-1:0]    gain,
    input  logic        [LIM_W-1:0]     max_cmd,
    input  logic        [LIM_W-1:0]     slew_step,
    input  logic        [BAND_W-1:0]    settle_band,
    input  dpds_lane_ctrl_t             ctrl,
    output logic                        in_band,
    output logic signed [SPEED_W-1:0]   speed
);

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SPEED_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic signed [SPEED_W-1:0] speed_reg, speed_next;
    logic signed [ERR_W-1:0]   err_raw, err;
    logic        [ERR_W-1:0]   err_abs;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [CMD_W-1:0]   cmd, lim_c, vel_c;
    logic signed [SPEED_W-1:0] vel_start;
    logic signed [SUM_W-1:0]   lim_s, step_s, vel_s, vel_sum;
    logic signed [SPEED_W-1:0] vel_sat;

    always_comb begin
        err_raw = ERR_W'(target) - ERR_W'(position);
        err     = negate ? -err_raw : err_raw;
        err_abs = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        in_band = (err_abs <= ERR_W'(settle_band));

        gain_s  = $signed({1'b0, gain});
        cmd     = CMD_W'(err) * CMD_W'(gain_s);

        vel_start = ctrl.restart ? '0 : speed_reg;
        lim_c     = CMD_W'($signed({1'b0, max_cmd}));
        vel_c     = CMD_W'(vel_start);
        lim_s     = SUM_W'($signed({1'b0, max_cmd}));
        step_s    = SUM_W'($signed({1'b0, slew_step}));
        vel_s     = SUM_W'(vel_start);

        // snap to the limit when the command exceeds it, else step toward the command
        if (cmd > lim_c) begin
            vel_sum = lim_s;
        end else if (cmd < -lim_c) begin
            vel_sum = -lim_s;
        end else if (cmd > vel_c) begin
            vel_sum = vel_s + step_s;
        end else if (cmd < vel_c) begin
            vel_sum = vel_s - step_s;
        end else begin
            vel_sum = vel_s;
        end

        if (vel_sum > SAT_HI) begin
            vel_sat = SPEED_W'(SAT_HI);
        end else if (vel_sum < SAT_LO) begin
            vel_sat = SPEED_W'(SAT_LO);
        end else begin
            vel_sat = SPEED_W'(vel_sum);
        end

        speed_next = speed_reg;
        if (ctrl.load) begin
            speed_next = ctrl.clear ? '0 : vel_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
        end else begin
            speed_reg <= speed_next;
        end
    end

    assign speed = speed_reg;

endmodule

// File: hdl/dpds_settle.sv
// ----------------------------------------------------------------------------
// dpds_settle
// Merges the two lanes' in-band flags: settle counter, done latch, and the
// per-word control that tells the lanes whether to update or clear.
// ----------------------------------------------------------------------------
module dpds_settle
    import dpds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                restart,
    input  logic                left_in_band,
    input  logic                right_in_band,
    input  logic [BAND_W-1:0]   settle_limit,
    output dpds_lane_ctrl_t     ctrl,
    output logic                done
);

    logic [COUNT_W-1:0] count_reg, count_next, count_start, count_calc;
    logic               done_reg, done_next, done_start, done_calc;
    logic               active;

    always_comb begin
        count_start = restart ? '0 : count_reg;
        done_start  = restart ? 1'b0 : done_reg;
        active      = accept && !done_start;

        if (!(left_in_band && right_in_band)) begin
            count_calc = '0;
        end else if (count_start == COUNT_MAX) begin
            count_calc = count_start;
        end else begin
            count_calc = count_start + COUNT_W'(1);
        end
        done_calc = (count_calc > COUNT_W'(settle_limit));

        // hold everything once done, until a restart word arrives
        count_next = count_reg;
        done_next  = done_reg;
        if (active) begin
            count_next = count_calc;
            done_next  = done_calc;
        end

        ctrl.restart = restart;
        ctrl.load    = active;
        ctrl.clear   = done_calc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

endmodule
